/* sv/rrbd_pkg.sv */
// Package for the RLE RGB565 blit decoder: the queue entry type, the entry
// kinds and the fixed field widths.
// No dependencies.
`default_nettype none

package rrbd_pkg;

  localparam int ROW_W   = 23;
  localparam int COL_W   = 13;
  localparam int WIDTH_W = 13;
  localparam int BYTES_W = 11;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int OUT_W   = 80;

  localparam logic [1:0] K_SETPOS = 2'd0;
  localparam logic [1:0] K_RUN    = 2'd1;
  localparam logic [1:0] K_END    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ROW_W-1:0]   idx;
    logic [15:0]        colour;
    logic [7:0]         len;
    logic               last;
    logic [BYTES_W-1:0] bytes;
  } item_t;

endpackage

`default_nettype wire

/* sv/rrbd_front.sv */
// Front end of the decoder: parses command bytes and queues position,
// run and end-of-command entries.
// Depends on rrbd_pkg.
`default_nettype none

module rrbd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    cmd_byte,
  input  wire logic          cmd_start,
  output rrbd_pkg::item_t    entry,
  output logic               push
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_TOTAL  = 3'd2;
  localparam logic [2:0] PH_RAWCNT = 3'd3;
  localparam logic [2:0] PH_PIXHI  = 3'd4;
  localparam logic [2:0] PH_PIXLO  = 3'd5;
  localparam logic [2:0] PH_REPEAT = 3'd6;
  localparam logic [2:0] PH_JUNK   = 3'd7;

  logic [2:0]                   phase, phase_next;
  logic [23:0]                  addr_accum, addr_accum_next;
  logic [8:0]                   total_pixels, total_pixels_next;
  logic [9:0]                   pixels_done, pixels_done_next;
  logic [8:0]                   span_left, span_left_next;
  logic [7:0]                   high_byte, high_byte_next;
  logic [15:0]                  last_colour, last_colour_next;
  logic [rrbd_pkg::BYTES_W-1:0] byte_count, byte_count_next;
  logic [rrbd_pkg::BYTES_W-1:0] bc_inc;
  logic [8:0]                   b_or_256;
  logic [8:0]                   span_dec;
  logic [9:0]                   pd_rep;

  always_comb begin
    bc_inc   = (byte_count == '1) ? byte_count : byte_count + 1'b1;
    b_or_256 = (cmd_byte == 8'd0) ? 9'd256 : {1'b0, cmd_byte};
    span_dec = (span_left != 9'd0) ? span_left - 9'd1 : 9'd0;
    pd_rep   = pixels_done + {2'b0, cmd_byte};

    phase_next        = phase;
    addr_accum_next   = addr_accum;
    total_pixels_next = total_pixels;
    pixels_done_next  = pixels_done;
    span_left_next    = span_left;
    high_byte_next    = high_byte;
    last_colour_next  = last_colour;
    byte_count_next   = byte_count;
    push              = 1'b0;
    entry             = '0;

    if (take) begin
      if (cmd_start) begin
        phase_next      = PH_ADDR;
        addr_accum_next = {16'd0, cmd_byte};
        byte_count_next = rrbd_pkg::BYTES_W'(1);
      end else begin
        if (phase != PH_IDLE) begin
          byte_count_next = bc_inc;
        end
        case (phase)
          PH_ADDR: begin
            addr_accum_next = {addr_accum[15:0], cmd_byte};
            if (bc_inc >= rrbd_pkg::BYTES_W'(3)) begin
              push        = 1'b1;
              entry.kind  = rrbd_pkg::K_SETPOS;
              entry.idx   = addr_accum_next[23:1];
              phase_next  = PH_TOTAL;
            end
          end
          PH_TOTAL: begin
            total_pixels_next = b_or_256;
            pixels_done_next  = '0;
            phase_next        = PH_RAWCNT;
          end
          PH_RAWCNT: begin
            span_left_next   = b_or_256;
            pixels_done_next = pixels_done + {1'b0, b_or_256};
            phase_next       = PH_PIXHI;
          end
          PH_PIXHI: begin
            high_byte_next = cmd_byte;
            phase_next     = PH_PIXLO;
          end
          PH_PIXLO: begin
            last_colour_next = {high_byte, cmd_byte};
            span_left_next   = span_dec;
            push             = 1'b1;
            entry.kind       = rrbd_pkg::K_RUN;
            entry.colour     = last_colour_next;
            entry.len        = 8'd1;
            if (span_dec == 9'd0) begin
              if (pixels_done >= {1'b0, total_pixels}) begin
                entry.last  = 1'b1;
                entry.bytes = bc_inc;
                phase_next  = PH_IDLE;
              end else begin
                phase_next = PH_REPEAT;
              end
            end else begin
              phase_next = PH_PIXHI;
            end
          end
          PH_REPEAT: begin
            pixels_done_next = pd_rep;
            phase_next = (pd_rep >= {1'b0, total_pixels}) ? PH_JUNK : PH_RAWCNT;
            if (cmd_byte != 8'd0) begin
              push         = 1'b1;
              entry.kind   = rrbd_pkg::K_RUN;
              entry.colour = last_colour;
              entry.len    = cmd_byte;
            end
          end
          PH_JUNK: begin
            push        = 1'b1;
            entry.kind  = rrbd_pkg::K_END;
            entry.last  = 1'b1;
            entry.bytes = bc_inc;
            phase_next  = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      addr_accum   <= '0;
      total_pixels <= '0;
      pixels_done  <= '0;
      span_left    <= '0;
      high_byte    <= '0;
      last_colour  <= '0;
      byte_count   <= '0;
    end else begin
      phase        <= phase_next;
      addr_accum   <= addr_accum_next;
      total_pixels <= total_pixels_next;
      pixels_done  <= pixels_done_next;
      span_left    <= span_left_next;
      high_byte    <= high_byte_next;
      last_colour  <= last_colour_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

/* sv/rrbd_fifo.sv */
// Short queue of parsed entries between the front end and the back end.
// Depends on rrbd_pkg.
`default_nettype none

module rrbd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rrbd_pkg::item_t wr_item,
  output logic               full,
  input  wire logic          pop,
  output rrbd_pkg::item_t    rd_item,
  output logic               empty
);

  rrbd_pkg::item_t                 mem [rrbd_pkg::QDEPTH];
  logic [rrbd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rrbd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rrbd_pkg::QPTR_W:0]       count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == (rrbd_pkg::QPTR_W + 1)'(rrbd_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/rrbd_back.sv */
// Back end of the decoder: keeps the write position, emits runs and end-of-command
// entries into the output register and updates row and column with a bit-serial divider.
// Depends on rrbd_pkg.
`default_nettype none

module rrbd_back #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rrbd_pkg::WIDTH_W-1:0]  line_width,
  input  wire rrbd_pkg::item_t               head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rrbd_pkg::OUT_W-1:0]         out_data,
  output logic                               out_user,
  output logic                               out_last
);

  localparam int ADV_W = rrbd_pkg::COL_W + 1;

  logic [rrbd_pkg::WIDTH_W-1:0] w;
  logic [rrbd_pkg::ROW_W-1:0]   cur_row;
  logic [rrbd_pkg::COL_W-1:0]   cur_col;

  logic                         busy;
  logic                         div_adv;
  logic [4:0]                   div_cnt;
  logic [rrbd_pkg::COL_W-1:0]   div_rem;
  logic [rrbd_pkg::ROW_W-1:0]   div_q;
  logic [rrbd_pkg::COL_W:0]     rem_sh;
  logic                         ge;
  logic [rrbd_pkg::COL_W-1:0]   rem_next;
  logic [rrbd_pkg::ROW_W-1:0]   q_next;
  logic [ADV_W-1:0]             adv_t;

  logic                         out_free;
  logic                         out_load;
  logic [rrbd_pkg::ROW_W-1:0]   o_row;
  logic [11:0]                  o_col;
  logic [7:0]                   o_len;
  logic [15:0]                  o_colour;
  logic [rrbd_pkg::BYTES_W-1:0] o_bytes;

  always_comb begin
    if (line_width == '0) begin
      w = rrbd_pkg::WIDTH_W'(1);
    end else if (32'(line_width) > 32'(MAX_LINE_WIDTH)) begin
      w = rrbd_pkg::WIDTH_W'(MAX_LINE_WIDTH);
    end else begin
      w = line_width;
    end
  end

  assign rem_sh   = {div_rem, div_q[rrbd_pkg::ROW_W-1]};
  assign ge       = (rem_sh >= {1'b0, w});
  assign rem_next = ge ? rrbd_pkg::COL_W'(rem_sh - {1'b0, w})
                       : rem_sh[rrbd_pkg::COL_W-1:0];
  assign q_next   = {div_q[rrbd_pkg::ROW_W-2:0], ge};
  assign adv_t    = {1'b0, cur_col} + {{(ADV_W-8){1'b0}}, head.len};

  assign out_free = !out_valid || out_ready;

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    if (!busy && !empty) begin
      case (head.kind)
        rrbd_pkg::K_RUN, rrbd_pkg::K_END: begin
          pop      = out_free;
          out_load = out_free;
        end
        default: pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      div_adv <= 1'b0;
      div_cnt <= '0;
      div_rem <= '0;
      div_q   <= '0;
      cur_row <= '0;
      cur_col <= '0;
    end else if (busy) begin
      div_rem <= rem_next;
      div_q   <= q_next;
      div_cnt <= div_cnt - 5'd1;
      if (div_cnt == 5'd1) begin
        busy    <= 1'b0;
        cur_col <= rem_next;
        cur_row <= div_adv ? cur_row + q_next : q_next;
      end
    end else if (pop) begin
      div_rem <= '0;
      if (head.kind == rrbd_pkg::K_SETPOS) begin
        busy    <= 1'b1;
        div_adv <= 1'b0;
        div_q   <= head.idx;
        div_cnt <= 5'(rrbd_pkg::ROW_W);
      end else if (head.kind == rrbd_pkg::K_RUN) begin
        busy    <= 1'b1;
        div_adv <= 1'b1;
        div_q   <= {adv_t, {(rrbd_pkg::ROW_W-ADV_W){1'b0}}};
        div_cnt <= 5'(ADV_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_last <= head.last;
      o_bytes  <= head.last ? head.bytes : '0;
      if (head.kind == rrbd_pkg::K_RUN) begin
        out_user <= 1'b1;
        o_row    <= cur_row;
        o_col    <= cur_col[11:0];
        o_len    <= head.len;
        o_colour <= head.colour;
      end else begin
        out_user <= 1'b0;
        o_row    <= '0;
        o_col    <= '0;
        o_len    <= '0;
        o_colour <= '0;
      end
    end
  end

  assign out_data = {2'b00, o_bytes,
                     o_colour[15:11], 3'b000,
                     o_colour[10:5], 2'b00,
                     o_colour[4:0], 3'b000,
                     o_len, o_col, o_row};

endmodule

`default_nettype wire

/* sv/rle_rgb565_blit_decoder.sv */
// Top level of the RLE RGB565 blit decoder: line width register, front end,
// entry queue and back end.
// Depends on rrbd_pkg, rrbd_front, rrbd_fifo and rrbd_back.
`default_nettype none

// Takes one command byte per cycle while the entry queue has room. Each
// pixel run, and the start position at the end of the header, then occupies
// the back end while its serial divider updates row and column, so the back
// end takes no new entry until the divider is done, while the four-entry
// queue absorbs the bytes between.
// Results wait in an output register, so the front keeps taking bytes while
// a result is stalled and the queue has room.
module rle_rgb565_blit_decoder #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rrbd_pkg::WIDTH_W-1:0]  cfg_wr_data,   // line_width
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // cmd_byte
  input  wire logic                          s_axis_tuser,  // cmd_start
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // start_row[22:0] start_col[34:23] run_length[42:35] blue[50:43]
  // green[58:51] red[66:59] bytes_used[77:67], zero pad[79:78]
  output logic [rrbd_pkg::OUT_W-1:0]         m_axis_tdata,
  output logic                               m_axis_tuser,  // pixel_valid
  output logic                               m_axis_tlast   // cmd_last
);

  logic [rrbd_pkg::WIDTH_W-1:0] line_width;
  rrbd_pkg::item_t              f_entry;
  rrbd_pkg::item_t              q_head;
  logic                         f_push;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= rrbd_pkg::WIDTH_W'(1024);
    end else if (cfg_wr_en) begin
      line_width <= cfg_wr_data;
    end
  end

  assign s_axis_tready = !q_full;

  rrbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (s_axis_tvalid && !q_full),
    .cmd_byte  (s_axis_tdata),
    .cmd_start (s_axis_tuser),
    .entry     (f_entry),
    .push      (f_push)
  );

  rrbd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_item (f_entry),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_head),
    .empty   (q_empty)
  );

  rrbd_back #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire
